### rtl/core/brudc_pkg.sv
// Shared types and constants for the button repeat up/down counter.
// Holds the beat structs of both channels, configuration indexes and reset values.
// No dependencies.
`default_nettype none

package brudc_pkg;

	localparam int HOLD_BITS_DEF = 8;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = 1'd1;

	localparam logic [3:0] MAX_VALUE_RST = 4'd9;
	localparam logic [7:0] FAST_THRESHOLD_RST = 8'd15;

	typedef struct packed {
		logic up_button;
		logic down_button;
	} btn_t;

	typedef struct packed {
		logic [3:0] value;
		logic [2:0] mode;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/button_repeat_up_down_counter.sv
// Top level of the button repeat up/down counter.
// Mode state machine, hold counter, saturating value and output register.
// Depends on brudc_pkg.
//
// Usage: each beat on the btn channel is one tick carrying two button levels.
// For every accepted beat exactly one beat leaves on the res channel with the
// displayed value and the mode after that tick.
// A beat is taken on a rising edge where its valid is high and its stall is low.
// Each result is registered and valid in the cycle after its tick is accepted.
// Throughput is one tick per cycle while res_stall is low, set by the single
// output register, refilled in the same cycle that it is emptied. When the
// receiver stalls while a result waits, btn_stall rises and the held result
// stays unchanged until it is taken. Reset puts the mode in start, clears the
// hold count and the value, and loads max_value with 9 and fast_threshold
// with 15. The user must write the registers through cfg_we, cfg_index and
// cfg_wdata only while no tick is in flight; the block does not enforce this.
`default_nettype none

module button_repeat_up_down_counter #(
	parameter int HOLD_BITS = brudc_pkg::HOLD_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   btn_valid,
	output logic                                  btn_stall,
	input  wire brudc_pkg::btn_t                  btn,
	output logic                                  res_valid,
	input  wire                                   res_stall,
	output brudc_pkg::res_t                       res,
	input  wire                                   cfg_we,
	input  wire [brudc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [brudc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import brudc_pkg::*;

	localparam int CMP_W = (HOLD_BITS > 8) ? HOLD_BITS : 8;

	typedef enum logic [2:0] {
		M_START = 3'd0,
		M_IDLE  = 3'd1,
		M_WAIT  = 3'd2,
		M_UP    = 3'd3,
		M_DOWN  = 3'd4,
		M_CLEAR = 3'd5
	} mode_t;

	mode_t                mode_q, mode_next;
	logic [HOLD_BITS-1:0] hold_q, hold_next;
	logic [2:0]           mod5_q, mod5_next;
	logic [3:0]           value_q, value_next;
	logic [3:0]           max_value_q;
	logic [7:0]           fast_threshold_q;
	logic                 accept;
	logic                 step_due;
	logic [CMP_W-1:0]     cnt_ext, thr_ext;
	logic                 up, dn;

	assign up = btn.up_button;
	assign dn = btn.down_button;
	assign btn_stall = res_valid & res_stall;
	assign accept = btn_valid & ~btn_stall;

	assign cnt_ext = CMP_W'(hold_q);
	assign thr_ext = CMP_W'(fast_threshold_q);

	always_comb begin
		if (cnt_ext != '0 && cnt_ext < thr_ext) begin
			step_due = (mod5_q == 3'd0);
		end else begin
			step_due = ~hold_q[1];
		end
	end

	always_comb begin
		unique case (mode_q)
			M_START: mode_next = M_IDLE;
			M_IDLE, M_WAIT: begin
				if (up && dn) mode_next = M_CLEAR;
				else if (up) mode_next = M_UP;
				else if (dn) mode_next = M_DOWN;
				else mode_next = mode_q;
			end
			M_UP: begin
				if (up && dn) mode_next = M_CLEAR;
				else if (up) mode_next = M_UP;
				else mode_next = M_WAIT;
			end
			M_DOWN: begin
				if (up && dn) mode_next = M_CLEAR;
				else if (dn) mode_next = M_DOWN;
				else mode_next = M_WAIT;
			end
			M_CLEAR: mode_next = (up && dn) ? M_CLEAR : M_IDLE;
			default: mode_next = M_START;
		endcase
	end

	// The modulo-5 tracker restarts whenever the hold count returns to zero.
	always_comb begin
		value_next = value_q;
		hold_next = hold_q;
		mod5_next = mod5_q;
		case (mode_next)
			M_IDLE, M_CLEAR: begin
				value_next = '0;
				hold_next = '0;
				mod5_next = '0;
			end
			M_WAIT: begin
				hold_next = '0;
				mod5_next = '0;
			end
			M_UP, M_DOWN: begin
				if (mode_next == M_UP) begin
					if (value_q < max_value_q && step_due) value_next = value_q + 4'd1;
				end else begin
					if (value_q != 4'd0 && step_due) value_next = value_q - 4'd1;
				end
				hold_next = hold_q + 1'b1;
				if (hold_q == '1 || mod5_q == 3'd4) mod5_next = '0;
				else mod5_next = mod5_q + 3'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			hold_q <= '0;
			mod5_q <= '0;
			value_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_next;
				hold_q <= hold_next;
				mod5_q <= mod5_next;
				value_q <= value_next;
				res.value <= value_next;
				res.mode <= mode_next;
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= MAX_VALUE_RST;
			fast_threshold_q <= FAST_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_VALUE: max_value_q <= cfg_wdata[3:0];
				CFG_FAST_THRESHOLD: fast_threshold_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the button repeat up/down counter: directed button
// sequences, then random presses and holds under several register settings.
// Depends on brudc_pkg and button_repeat_up_down_counter.

module tb_top;

	import brudc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_W = HOLD_BITS_DEF;

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_IDLE  = 3'd1,
		MODE_WAIT  = 3'd2,
		MODE_UP    = 3'd3,
		MODE_DOWN  = 3'd4,
		MODE_CLEAR = 3'd5
	} mode_e;

	localparam btn_t PRESS_NONE = '{up_button: 1'b0, down_button: 1'b0};
	localparam btn_t PRESS_UP   = '{up_button: 1'b1, down_button: 1'b0};
	localparam btn_t PRESS_DOWN = '{up_button: 1'b0, down_button: 1'b1};
	localparam btn_t PRESS_BOTH = '{up_button: 1'b1, down_button: 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic btn_valid = 1'b0;
	logic btn_stall;
	btn_t btn = PRESS_NONE;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_VALUE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	btn_t pending_ticks[$];
	res_t expected_res[$];
	logic tick_taken = 1'b0;
	int tick_gap_pct = 0;
	int res_stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	res_t seen;
	res_t want;

	// Shadow copy of the counter state and its registers.
	mode_e cur_mode = MODE_START;
	logic [HOLD_W-1:0] hold_cnt = '0;
	logic [3:0] shown_val = '0;
	logic [3:0] max_lim = MAX_VALUE_RST;
	logic [7:0] fast_thr = FAST_THRESHOLD_RST;

	button_repeat_up_down_counter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.btn_valid(btn_valid),
		.btn_stall(btn_stall),
		.btn(btn),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic repeat_due(logic [HOLD_W-1:0] cnt);
		if (cnt > 0 && cnt < fast_thr) begin
			return (cnt % 5) == 0;
		end
		if (cnt >= fast_thr) begin
			return cnt[1] == 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic res_t count_tick(btn_t b);
		logic up;
		logic dn;
		res_t r;
		up = b.up_button;
		dn = b.down_button;
		case (cur_mode)
			MODE_START: begin
				cur_mode = MODE_IDLE;
			end
			MODE_IDLE, MODE_WAIT: begin
				if (up && dn) cur_mode = MODE_CLEAR;
				else if (up) cur_mode = MODE_UP;
				else if (dn) cur_mode = MODE_DOWN;
			end
			MODE_UP: begin
				if (up && dn) cur_mode = MODE_CLEAR;
				else cur_mode = up ? MODE_UP : MODE_WAIT;
			end
			MODE_DOWN: begin
				if (up && dn) cur_mode = MODE_CLEAR;
				else cur_mode = dn ? MODE_DOWN : MODE_WAIT;
			end
			MODE_CLEAR: begin
				cur_mode = (up && dn) ? MODE_CLEAR : MODE_IDLE;
			end
			default: begin
				cur_mode = MODE_START;
			end
		endcase
		case (cur_mode)
			MODE_IDLE, MODE_CLEAR: begin
				hold_cnt = '0;
				shown_val = '0;
			end
			MODE_WAIT: begin
				hold_cnt = '0;
			end
			MODE_UP: begin
				if (shown_val < max_lim && repeat_due(hold_cnt)) shown_val = shown_val + 4'd1;
				hold_cnt = hold_cnt + 1'b1;
			end
			MODE_DOWN: begin
				if (shown_val > 0 && repeat_due(hold_cnt)) shown_val = shown_val - 4'd1;
				hold_cnt = hold_cnt + 1'b1;
			end
			default: begin
			end
		endcase
		r.value = shown_val;
		r.mode = cur_mode;
		return r;
	endfunction

	// Driver: a beat stays on the bus until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!btn_valid || tick_taken)) begin
			if (pending_ticks.size() > 0 && $urandom_range(99) >= tick_gap_pct) begin
				btn <= pending_ticks.pop_front();
				btn_valid <= 1'b1;
			end else begin
				btn_valid <= 1'b0;
			end
		end
		res_stall <= ($urandom_range(99) < res_stall_pct);
	end

	// Monitor: predicts on every accepted tick and checks every result beat.
	always @(posedge clk) begin
		tick_taken <= btn_valid && !btn_stall;
		if (btn_valid && !btn_stall) begin
			expected_res.push_back(count_tick(btn));
		end
		if (res_valid && !res_stall) begin
			seen = res;
			if (expected_res.size() == 0) begin
				$error("result beat with no tick pending: value %0d mode %0d",
					seen.value, seen.mode);
				error_count++;
			end else begin
				want = expected_res.pop_front();
				if (seen.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, seen.value);
					error_count++;
				end
				if (seen.mode !== want.mode) begin
					$error("mode: expected %0d, got %0d", want.mode, seen.mode);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((btn_valid && !btn_stall) || (res_valid && !res_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic hold_buttons(btn_t b, int len);
		repeat (len) pending_ticks.push_back(b);
	endtask

	task automatic add_random_ticks(int budget);
		int made;
		int len;
		int pick;
		btn_t b;
		made = 0;
		while (made < budget) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				len = $urandom_range(6, 1);
				if (len > budget - made) len = budget - made;
				repeat (len) pending_ticks.push_back(btn_t'($urandom_range(3)));
			end else begin
				if (pick < 50) b = PRESS_UP;
				else if (pick < 80) b = PRESS_DOWN;
				else if (pick < 90) b = PRESS_BOTH;
				else b = PRESS_NONE;
				if ((b == PRESS_UP || b == PRESS_DOWN) && $urandom_range(14) == 0) begin
					len = $urandom_range(300, 240);
				end else begin
					len = $urandom_range(40, 1);
				end
				if (len > budget - made) len = budget - made;
				hold_buttons(b, len);
			end
			made += len;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == CFG_MAX_VALUE) max_lim = data[3:0];
		else fast_thr = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_ticks.size() > 0 || btn_valid || expected_res.size() > 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					tick_gap_pct = 8;
					res_stall_pct = 45;
				end
				1: begin
					tick_gap_pct = 45;
					res_stall_pct = 8;
				end
				default: begin
					tick_gap_pct = 0;
					res_stall_pct = 0;
				end
			endcase
			case (phase)
				0: begin
					hold_buttons(PRESS_NONE, 2);
					hold_buttons(PRESS_UP, 13);
					hold_buttons(PRESS_UP, 4);
					hold_buttons(PRESS_DOWN, 2);
					hold_buttons(PRESS_BOTH, 2);
					hold_buttons(PRESS_NONE, 1);
					hold_buttons(PRESS_DOWN, 1);
				end
				1: begin
					write_reg(CFG_MAX_VALUE, 8'd15);
					write_reg(CFG_FAST_THRESHOLD, 8'd255);
				end
				2: begin
					write_reg(CFG_MAX_VALUE, 8'd1);
					write_reg(CFG_FAST_THRESHOLD, 8'd1);
					hold_buttons(PRESS_DOWN, 260);
				end
				3: begin
					write_reg(CFG_MAX_VALUE, 8'd0);
					write_reg(CFG_FAST_THRESHOLD, 8'd0);
				end
				4: begin
					write_reg(CFG_MAX_VALUE, 8'd15);
				end
				default: begin
					// The counter is left at its top value, so the new limit sits below it.
					write_reg(CFG_MAX_VALUE, 8'd4);
					write_reg(CFG_FAST_THRESHOLD, 8'd7);
					hold_buttons(PRESS_UP, 3);
					hold_buttons(PRESS_DOWN, 14);
				end
			endcase
			add_random_ticks(phase == 2 ? 60 : 110);
			if (phase == 4) begin
				hold_buttons(PRESS_NONE, 1);
				hold_buttons(PRESS_UP, 40);
			end
			wait_drained();
		end

		if (expected_res.size() > 0) begin
			$error("%0d result beats never arrived", expected_res.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
